// ===== rtl/slms_pkg.sv =====
// Shared types, constants and colour codes for the status LED sequencer.
package slms_pkg;

    localparam int NOW_W      = 32;
    localparam int HOLD_W     = 16;
    localparam int PCT_W      = 7;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item kinds.
    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_SET = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_HOLD  = 2'd2;

    localparam logic [HOLD_W-1:0] BLINK_HALF_RESET = 16'd250;
    localparam logic [HOLD_W-1:0] CONN_HOLD_RESET  = 16'd5000;
    localparam logic [HOLD_W-1:0] DISC_HOLD_RESET  = 16'd2000;

    // Battery ramp breakpoints.
    localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;
    localparam logic [PCT_W-1:0] PCT_LOW_LIMIT  = 7'd20;
    localparam logic [PCT_W-1:0] PCT_MID_START  = 7'd21;
    localparam logic [PCT_W-1:0] PCT_HIGH_START = 7'd60;

    // 255/40 reduces to 51/8, so the upper ramp is exact with a shift.
    localparam logic [10:0] RED_SLOPE = 11'd51;
    localparam int          RED_SHIFT = 3;

    // Division by 38 done as multiplication by a scaled reciprocal.
    localparam logic [13:0] MID_SCALE   = 14'd255;
    localparam logic [28:0] GREEN_RECIP = 29'd27595;
    localparam int          GREEN_SHIFT = 20;

    localparam logic [CH_W-1:0] CH_FULL = 8'd255;

    typedef enum logic [1:0] {
        MODE_DISCONNECTED   = 2'd0,
        MODE_PAIRING        = 2'd1,
        MODE_JUST_CONNECTED = 2'd2,
        MODE_TRACKING       = 2'd3
    } t_link_mode;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    localparam t_rgb RGB_BLACK  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam t_rgb RGB_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
    localparam t_rgb RGB_BLUE   = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
    localparam t_rgb RGB_ORANGE = '{red: 8'd255, green: 8'd128, blue: 8'd0};
    localparam t_rgb RGB_PURPLE = '{red: 8'd128, green: 8'd0,   blue: 8'd128};

    typedef struct packed {
        logic [HOLD_W-1:0] blink_half_ms;
        logic [HOLD_W-1:0] conn_hold_ms;
        logic [HOLD_W-1:0] disc_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [NOW_W-1:0] now_ms;
        logic [1:0]       new_mode;
        logic             link_switch_on;
        logic             battery_valid;
        logic [PCT_W-1:0] battery_percent;
    } t_in_item;

endpackage

// ===== rtl/slms_in_if.sv =====
// Input channel: valid/ready handshake carrying one update item.
interface slms_in_if import slms_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [NOW_W-1:0] now_ms;
    logic [1:0]       new_mode;
    logic             link_switch_on;
    logic             battery_valid;
    logic [PCT_W-1:0] battery_percent;

    modport source (
        output valid, kind, now_ms, new_mode, link_switch_on, battery_valid,
               battery_percent,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, new_mode, link_switch_on, battery_valid,
               battery_percent,
        output ready
    );
endinterface

// ===== rtl/slms_out_if.sv =====
// Output channel: valid/ready handshake carrying one LED colour item.
interface slms_out_if import slms_pkg::*; ;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/slms_cfg_regs.sv =====
// Configuration registers for blink period and hold times.
module slms_cfg_regs import slms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_half_ms <= BLINK_HALF_RESET;
            r_cfg.conn_hold_ms  <= CONN_HOLD_RESET;
            r_cfg.disc_hold_ms  <= DISC_HOLD_RESET;
        end else if (i_we) begin
            unique case (i_idx)
                REG_BLINK_HALF: r_cfg.blink_half_ms <= i_data;
                REG_CONN_HOLD:  r_cfg.conn_hold_ms  <= i_data;
                REG_DISC_HOLD:  r_cfg.disc_hold_ms  <= i_data;
                default: begin
                    // Writes to an unknown index are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/slms_battery_map.sv =====
// Maps a battery percentage to an LED colour on the red-to-green ramp, blinking red at or below the low limit.
module slms_battery_map import slms_pkg::*; (
    input  logic [PCT_W-1:0] i_percent,
    input  logic             i_phase,
    output t_rgb             o_color
);

    logic [PCT_W-1:0] pct_sat;
    logic [5:0]       hi_off;
    logic [10:0]      red_drop;
    logic [5:0]       mid_off;
    logic [13:0]      mid_scaled;
    logic [28:0]      green_prod;

    always_comb begin
        pct_sat    = (i_percent > PCT_MAX) ? PCT_MAX : i_percent;
        hi_off     = 6'(pct_sat - PCT_HIGH_START);
        red_drop   = 11'(hi_off) * RED_SLOPE;
        mid_off    = 6'(pct_sat - PCT_MID_START);
        mid_scaled = 14'(mid_off) * MID_SCALE;
        green_prod = 29'(mid_scaled) * GREEN_RECIP;

        priority if (pct_sat <= PCT_LOW_LIMIT) begin
            o_color = i_phase ? RGB_RED : RGB_BLACK;
        end else if (pct_sat >= PCT_HIGH_START) begin
            o_color.red   = CH_FULL - 8'(red_drop >> RED_SHIFT);
            o_color.green = CH_FULL;
            o_color.blue  = '0;
        end else begin
            o_color.red   = CH_FULL;
            o_color.green = 8'(green_prod >> GREEN_SHIFT);
            o_color.blue  = '0;
        end
    end

endmodule

// ===== rtl/slms_engine.sv =====
// Link mode state machine, blink timing and colour selection for one item.
module slms_engine import slms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_rgb     o_color
);

    t_link_mode       r_mode;
    t_link_mode       n_mode;
    logic [NOW_W-1:0] r_deadline;
    logic [NOW_W-1:0] n_deadline;
    logic             r_phase;
    logic [NOW_W-1:0] r_last_flip;
    t_rgb             r_shown;

    logic [NOW_W-1:0] elapsed;
    logic             is_run;
    logic             flip;
    logic             phase;
    logic             due;
    t_rgb             batt_color;
    t_rgb             color;

    // Wrap-safe age of the last flip: modular subtraction.
    always_comb begin
        is_run  = (i_item.kind == KIND_RUN);
        elapsed = i_item.now_ms - r_last_flip;
        flip    = is_run && (elapsed >= NOW_W'(i_cfg.blink_half_ms));
        phase   = r_phase ^ flip;
        due     = (i_item.now_ms >= r_deadline);
    end

    slms_battery_map u_battery_map (
        .i_percent (i_item.battery_percent),
        .i_phase   (phase),
        .o_color   (batt_color)
    );

    // Next state of the link mode and its hold deadline.
    always_comb begin
        n_mode     = r_mode;
        n_deadline = r_deadline;
        if (!is_run) begin
            n_mode = t_link_mode'(i_item.new_mode);
            if (t_link_mode'(i_item.new_mode) == MODE_JUST_CONNECTED) begin
                n_deadline = i_item.now_ms + NOW_W'(i_cfg.conn_hold_ms);
            end else if (t_link_mode'(i_item.new_mode) == MODE_DISCONNECTED) begin
                n_deadline = i_item.now_ms + NOW_W'(i_cfg.disc_hold_ms);
            end
        end else if (i_item.link_switch_on) begin
            unique case (r_mode)
                MODE_JUST_CONNECTED: if (due) n_mode = MODE_TRACKING;
                MODE_DISCONNECTED:   if (due) n_mode = MODE_PAIRING;
                default: begin
                end
            endcase
        end
    end

    // Colour shown for a run item.
    always_comb begin
        if (!i_item.link_switch_on) begin
            color = i_item.battery_valid ? batt_color
                                         : (phase ? RGB_PURPLE : RGB_BLACK);
        end else begin
            unique case (r_mode)
                MODE_PAIRING:        color = phase ? RGB_BLUE : RGB_BLACK;
                MODE_JUST_CONNECTED: color = RGB_BLUE;
                MODE_DISCONNECTED:   color = phase ? RGB_ORANGE : RGB_BLACK;
                MODE_TRACKING:       color = i_item.battery_valid ? batt_color : r_shown;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISCONNECTED;
            r_deadline  <= '0;
            r_phase     <= 1'b0;
            r_last_flip <= '0;
            r_shown     <= RGB_BLACK;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_deadline <= n_deadline;
            if (is_run) begin
                r_phase <= phase;
                r_shown <= color;
                if (flip) begin
                    r_last_flip <= i_item.now_ms;
                end
            end
        end
    end

    assign o_color = color;

endmodule

// ===== rtl/status_led_mode_sequencer.sv =====
// Status LED sequencer top level: input register, mode engine, result register.
// Flow: a run item accepted into the input register passes through the mode engine, and its
// colour item is registered in the output register, which offers it on the output.
// Throughput: one item per cycle unless stalled; a set-mode item gives no result and needs no output slot.
// The input register stalls only while a run item waits for the output register to drain.
// Reset is synchronous: it empties both registers, sets the link mode to disconnected,
// clears the blink phase, timestamps and shown colour, and loads the default config.
module status_led_mode_sequencer import slms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    slms_in_if.sink               i_in,
    slms_out_if.source            o_out
);

    t_cfg     cfg;
    t_in_item r_in;
    logic     r_in_valid;
    logic     r_out_valid;
    t_rgb     r_out_color;
    t_rgb     color;
    logic     fire;
    logic     load_out;

    slms_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // A set-mode item retires at once; a run item needs room in the output register.
    assign fire     = r_in_valid && ((r_in.kind == KIND_SET) || !r_out_valid || o_out.ready);
    assign load_out = fire && (r_in.kind == KIND_RUN);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.kind            <= i_in.kind;
            r_in.now_ms          <= i_in.now_ms;
            r_in.new_mode        <= i_in.new_mode;
            r_in.link_switch_on  <= i_in.link_switch_on;
            r_in.battery_valid   <= i_in.battery_valid;
            r_in.battery_percent <= i_in.battery_percent;
        end
    end

    slms_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_color (color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_color <= color;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_out_color.red;
    assign o_out.green = r_out_color.green;
    assign o_out.blue  = r_out_color.blue;

endmodule

// ===== rtl/slms_checker.sv =====
// Port-level assertions for the status LED sequencer, bound to the top level.
module slms_checker import slms_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_in_kind,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_out_red,
    input logic [CH_W-1:0] i_out_green,
    input logic [CH_W-1:0] i_out_blue
);

    // A stalled colour item stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue)))
        else $error("output item changed or dropped while stalled");

    // Reset leaves no colour item on offer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A run item that finds the output stalled blocks further input.
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_in_valid && i_in_ready && (i_in_kind == KIND_RUN))
            ##1 (i_out_valid && !i_out_ready)) |-> !i_in_ready)
        else $error("input taken while a run item waits for output space");

    // A fresh colour item comes from an accepted run item via both registers.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_in_kind == KIND_RUN), 2))
        else $error("output item without a matching run item");

endmodule

bind status_led_mode_sequencer slms_checker u_slms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_red   (o_out.red),
    .i_out_green (o_out.green),
    .i_out_blue  (o_out.blue)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the status LED sequencer: random and directed items, colour scoreboard.
module tb_top import slms_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_PHASES   = 7;
    localparam int RANDOM_ITEMS = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic     drv_valid  = 1'b0;
    t_in_item drv_item   = '0;
    logic     sink_ready = 1'b0;

    slms_in_if  in_if ();
    slms_out_if out_if ();

    assign in_if.valid           = drv_valid;
    assign in_if.kind            = drv_item.kind;
    assign in_if.now_ms          = drv_item.now_ms;
    assign in_if.new_mode        = drv_item.new_mode;
    assign in_if.link_switch_on  = drv_item.link_switch_on;
    assign in_if.battery_valid   = drv_item.battery_valid;
    assign in_if.battery_percent = drv_item.battery_percent;
    assign out_if.ready          = sink_ready;

    status_led_mode_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Predicted copy of the sequencer's configuration and state.
    logic [HOLD_W-1:0] blink_half  = BLINK_HALF_RESET;
    logic [HOLD_W-1:0] conn_hold   = CONN_HOLD_RESET;
    logic [HOLD_W-1:0] disc_hold   = DISC_HOLD_RESET;
    t_link_mode        link_mode   = MODE_DISCONNECTED;
    logic [NOW_W-1:0]  hold_until  = '0;
    logic              blink_lit   = 1'b0;
    logic [NOW_W-1:0]  last_flip   = '0;
    t_rgb              shown_rgb   = RGB_BLACK;

    t_in_item pending_items[$];
    t_rgb     expected_colours[$];

    int src_idle_pct    = 12;
    int snk_idle_pct    = 77;
    int fail_count      = 0;
    int items_accepted  = 0;
    int colours_checked = 0;
    int stall_cycles    = 0;

    function automatic t_rgb lit_or_dark(input t_rgb lit);
        return blink_lit ? lit : RGB_BLACK;
    endfunction

    function automatic t_rgb battery_rgb(input logic [PCT_W-1:0] pct);
        int   p;
        t_rgb c;
        p = (pct > PCT_MAX) ? int'(PCT_MAX) : int'(pct);
        c = RGB_BLACK;
        if (p <= int'(PCT_LOW_LIMIT)) begin
            c = lit_or_dark(RGB_RED);
        end else if (p >= int'(PCT_HIGH_START)) begin
            c.red   = 8'(255 - ((p - 60) * 255) / 40);
            c.green = 8'd255;
        end else begin
            c.red   = 8'd255;
            c.green = 8'(((p - 21) * 255) / 38);
        end
        return c;
    endfunction

    task automatic predict_colour(input t_in_item it);
        logic [NOW_W-1:0] elapsed;
        t_rgb             colour;
        if (it.kind == KIND_SET) begin
            link_mode = t_link_mode'(it.new_mode);
            if (link_mode == MODE_JUST_CONNECTED)
                hold_until = it.now_ms + NOW_W'(conn_hold);
            else if (link_mode == MODE_DISCONNECTED)
                hold_until = it.now_ms + NOW_W'(disc_hold);
        end else begin
            elapsed = it.now_ms - last_flip;
            if (elapsed >= NOW_W'(blink_half)) begin
                blink_lit = ~blink_lit;
                last_flip = it.now_ms;
            end
            if (!it.link_switch_on) begin
                colour = it.battery_valid ? battery_rgb(it.battery_percent)
                                          : lit_or_dark(RGB_PURPLE);
            end else begin
                case (link_mode)
                    MODE_PAIRING: begin
                        colour = lit_or_dark(RGB_BLUE);
                    end
                    MODE_JUST_CONNECTED: begin
                        colour = RGB_BLUE;
                        if (it.now_ms >= hold_until)
                            link_mode = MODE_TRACKING;
                    end
                    MODE_DISCONNECTED: begin
                        colour = lit_or_dark(RGB_ORANGE);
                        if (it.now_ms >= hold_until)
                            link_mode = MODE_PAIRING;
                    end
                    default: begin
                        colour = it.battery_valid ? battery_rgb(it.battery_percent)
                                                  : shown_rgb;
                    end
                endcase
            end
            shown_rgb = colour;
            expected_colours.push_back(colour);
        end
    endtask

    // Driver: holds an item until it is taken, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) begin
                predict_colour(drv_item);
                items_accepted++;
            end
            if (!drv_valid || in_if.ready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    drv_item  <= pending_items.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each colour item with the oldest prediction.
    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_if.valid && sink_ready) begin
                if (expected_colours.size() == 0) begin
                    $error("unexpected colour item %0d/%0d/%0d",
                           out_if.red, out_if.green, out_if.blue);
                    fail_count++;
                end else begin
                    want = expected_colours.pop_front();
                    colours_checked++;
                    if (out_if.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, out_if.red);
                        fail_count++;
                    end
                    if (out_if.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, out_if.green);
                        fail_count++;
                    end
                    if (out_if.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, out_if.blue);
                        fail_count++;
                    end
                end
            end
            sink_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((drv_valid && in_if.ready) || (out_if.valid && sink_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_run(input logic [NOW_W-1:0] now, input logic sw, input logic ok,
                            input logic [PCT_W-1:0] pct);
        t_in_item it;
        it.kind            = KIND_RUN;
        it.now_ms          = now;
        it.new_mode        = 2'($urandom());
        it.link_switch_on  = sw;
        it.battery_valid   = ok;
        it.battery_percent = pct;
        pending_items.push_back(it);
    endtask

    task automatic push_set(input logic [NOW_W-1:0] now, input t_link_mode mode);
        t_in_item it;
        it.kind            = KIND_SET;
        it.now_ms          = now;
        it.new_mode        = mode;
        it.link_switch_on  = 1'($urandom());
        it.battery_valid   = 1'($urandom());
        it.battery_percent = 7'($urandom());
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_BLINK_HALF: blink_half = data;
            REG_CONN_HOLD:  conn_hold  = data;
            REG_DISC_HOLD:  disc_hold  = data;
            default: ;
        endcase
    endtask

    // Wait until every item has gone in and every colour has come out,
    // then give the pipeline time to finish any set-mode item.
    task automatic wait_drained();
        while (pending_items.size() != 0 || drv_valid || expected_colours.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_link_mode pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return MODE_DISCONNECTED;
        if (r < 8) return MODE_JUST_CONNECTED;
        if (r < 9) return MODE_PAIRING;
        return MODE_TRACKING;
    endfunction

    function automatic logic [PCT_W-1:0] pick_pct();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom());
        return 7'($urandom_range(0, 100));
    endfunction

    function automatic logic [NOW_W-1:0] next_step();
        int r;
        int b;
        r = $urandom_range(0, 99);
        b = int'(blink_half);
        if (r < 15) return $urandom_range(0, 3);
        if (r < 35) return $urandom_range(b + 1, (b > 0) ? b - 1 : 0);
        if (r < 75) return $urandom_range(0, 600);
        if (r < 95) return $urandom_range(0, 70000);
        return $urandom();
    endfunction

    // Mostly sessions that set a mode and then advance time; some pure noise.
    task automatic add_random_items(input int count);
        int               made;
        int               runs;
        logic [NOW_W-1:0] t;
        t_in_item         it;
        made = 0;
        t = $urandom();
        while (made < count) begin
            if ($urandom_range(0, 99) < 12) begin
                it.kind            = 1'($urandom());
                it.now_ms          = $urandom();
                it.new_mode        = 2'($urandom());
                it.link_switch_on  = 1'($urandom());
                it.battery_valid   = 1'($urandom());
                it.battery_percent = 7'($urandom());
                pending_items.push_back(it);
                made++;
            end else begin
                case ($urandom_range(0, 4))
                    0, 1: t = $urandom();
                    2: t = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                    default: ;
                endcase
                push_set(t, pick_mode());
                made++;
                runs = $urandom_range(4, 30);
                repeat (runs) begin
                    t = t + next_step();
                    if ($urandom_range(0, 99) < 8)
                        push_set(t, t_link_mode'($urandom_range(0, 3)));
                    else
                        push_run(t, $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 85,
                                 pick_pct());
                    made++;
                end
            end
        end
    endtask

    task automatic add_directed_items();
        // Battery ramp with the switch off, including a reading above full scale.
        push_run(32'd0,   1'b0, 1'b1, 7'd0);
        push_run(32'd250, 1'b0, 1'b1, 7'd20);
        push_run(32'd251, 1'b0, 1'b1, 7'd21);
        push_run(32'd260, 1'b0, 1'b1, 7'd59);
        push_run(32'd270, 1'b0, 1'b1, 7'd60);
        push_run(32'd280, 1'b0, 1'b1, 7'd100);
        push_run(32'd290, 1'b0, 1'b1, 7'd127);
        push_run(32'd500, 1'b0, 1'b0, 7'd50);
        push_run(32'd750, 1'b0, 1'b0, 7'd50);
        // Disconnected hold runs out into pairing.
        push_set(32'd1000, MODE_DISCONNECTED);
        push_run(32'd1100, 1'b1, 1'b1, 7'd50);
        push_run(32'd3000, 1'b1, 1'b1, 7'd50);
        push_run(32'd3100, 1'b1, 1'b1, 7'd50);
        // Connected hold runs out into tracking, then the last colour is held.
        push_set(32'd4000, MODE_JUST_CONNECTED);
        push_run(32'd4001, 1'b1, 1'b1, 7'd50);
        push_run(32'd9000, 1'b1, 1'b1, 7'd50);
        push_run(32'd9001, 1'b1, 1'b1, 7'd80);
        push_run(32'd9002, 1'b1, 1'b0, 7'd10);
        // Pairing and tracking leave the deadline alone.
        push_set(32'd9100, MODE_PAIRING);
        push_set(32'd9200, MODE_TRACKING);
        push_run(32'd9300, 1'b1, 1'b1, 7'd5);
        push_run(32'hFFFF_FFFF, 1'b1, 1'b1, 7'd127);
        // Deadline that wraps past zero.
        push_set(32'hFFFF_FFF0, MODE_JUST_CONNECTED);
        push_run(32'hFFFF_FFF8, 1'b1, 1'b1, 7'd90);
        push_run(32'h0000_0010, 1'b1, 1'b0, 7'd0);
    endtask

    initial begin
        logic [HOLD_W-1:0] blink_set[NUM_PHASES];
        logic [HOLD_W-1:0] conn_set[NUM_PHASES];
        logic [HOLD_W-1:0] disc_set[NUM_PHASES];
        blink_set = '{16'd250,  16'd1,     16'd65535, 16'd0,   16'd100, 16'd3,     16'd40};
        conn_set  = '{16'd5000, 16'd0,     16'd65535, 16'd300, 16'd1,   16'd65535, 16'd1500};
        disc_set  = '{16'd2000, 16'd65535, 16'd0,     16'd250, 16'd2,   16'd0,     16'd800};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph < 3) begin
                src_idle_pct = 12;
                snk_idle_pct = 77;
            end else if (ph < 5) begin
                src_idle_pct = 77;
                snk_idle_pct = 12;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_reg(REG_BLINK_HALF, blink_set[ph]);
            write_reg(REG_CONN_HOLD, conn_set[ph]);
            write_reg(REG_DISC_HOLD, disc_set[ph]);
            // An index with no register behind it must change nothing.
            write_reg(REG_UNUSED, 16'($urandom()));
            @(posedge i_clk);
            cfg_we <= 1'b0;
            if (ph == 0)
                add_directed_items();
            else
                add_random_items(RANDOM_ITEMS / (NUM_PHASES - 1));
        end

        wait_drained();
        if (expected_colours.size() != 0) begin
            $error("%0d colour items never arrived", expected_colours.size());
            fail_count++;
        end

        $display("Ran %0d items over %0d configuration phases, %0d colour items checked.",
                 items_accepted, NUM_PHASES, colours_checked);
        $display("Phases covered blink, hold and idle extremes; %0d mismatches seen.",
                 fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
